// ===== design/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic task scheduler package
// Shared types and constants for the scheduler and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

    localparam int PERIOD_W   = 32;
    localparam int PRIO_W     = 4;
    localparam int TICK_W     = 16;
    localparam int TASK_IDX_W = 4;

    localparam logic [PRIO_W-1:0] PRIO_LIMIT = 4'd10;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_RUN   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STATUS_DONE     = 2'd0,
        STATUS_REJECTED = 2'd1,
        STATUS_NO_READY = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_TICK_RD,
        ST_TICK_WR,
        ST_RUN_RD,
        ST_RUN_CMP,
        ST_RUN_FETCH,
        ST_RUN_ARM,
        ST_RESP
    } t_state;

    typedef struct packed {
        t_status                 status;
        logic [TASK_IDX_W-1:0]   task_index;
        logic                    dispatch;
    } t_result;

endpackage

`default_nettype wire

// ===== design/pts_if.sv =====
// ----------------------------------------------------------------------------
// Scheduler channel interfaces
// Valid/ready channels for scheduler requests and scheduler results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pts_req_if import pts_pkg::*; ();
    logic                valid;
    logic                ready;
    t_func               func;
    logic                handler_present;
    logic [PERIOD_W-1:0] period;
    logic [PRIO_W-1:0]   priority_req;

    modport source (output valid, func, handler_present, period, priority_req, input ready);
    modport sink   (input valid, func, handler_present, period, priority_req, output ready);
endinterface

interface pts_rsp_if import pts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_status               status;
    logic [TASK_IDX_W-1:0] task_index;
    logic                  dispatch;

    modport source (output valid, status, task_index, dispatch, input ready);
    modport sink   (input valid, status, task_index, dispatch, output ready);
endinterface

`default_nettype wire

// ===== design/pts_ram.sv =====
// ----------------------------------------------------------------------------
// Generic scheduler RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/periodic_task_priority_scheduler.sv =====
// ----------------------------------------------------------------------------
// Periodic task priority scheduler
// Task table with add, clear, countdown tick and priority selection of a
// ready task, walked one table entry at a time by a small sequencer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transaction
//  i_req     in         func, handler_present, period, priority_req
//  o_rsp     out        status, task_index, dispatch
//  i_cfg_*   in         tick_size write, no read-back
//
//  A clear goes from acceptance straight to the result state, an add through
//  the add state. A tick reads and rewrites each countdown entry in turn, a run
//  reads each priority entry in turn and then re-arms the picked task's countdown.
//  Reset is synchronous and active low; the table RAMs are not cleared.
//  A finished result waits in the output register while the next request
//  is accepted; only a second result stalls the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_priority_scheduler import pts_pkg::*; #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [TICK_W-1:0] i_cfg_wdata,
    pts_req_if.sink                i_req,
    pts_rsp_if.source              o_rsp
);

    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int ADDR_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    t_state r_state, n_state;

    logic [TICK_W-1:0]    r_tick_size;
    logic [CNT_W-1:0]     r_total;
    logic [CNT_W-1:0]     r_idx;
    logic [MAX_TASKS-1:0] r_ready;
    logic [ADDR_W-1:0]    r_pick;
    logic [PRIO_W-1:0]    r_best;
    logic                 r_found;

    logic                 r_handler;
    logic [PERIOD_W-1:0]  r_period;
    logic [PRIO_W-1:0]    r_prio;

    t_result              r_res;
    t_result              r_out;
    logic                 r_out_valid;

    logic                 cd_we;
    logic [ADDR_W-1:0]    cd_waddr;
    logic [PERIOD_W-1:0]  cd_wdata;
    logic [PERIOD_W-1:0]  cd_rdata;
    logic                 tab_we;
    logic [PERIOD_W-1:0]  per_rdata;
    logic [PRIO_W-1:0]    prio_rdata;

    logic [ADDR_W-1:0]    idx_addr;
    logic [ADDR_W-1:0]    total_addr;
    logic [PERIOD_W:0]    diff;
    logic                 cd_expired;
    logic                 add_ok;
    logic                 scan_end;
    logic                 out_free;

    assign idx_addr   = r_idx[ADDR_W-1:0];
    assign total_addr = r_total[ADDR_W-1:0];
    assign diff       = {1'b0, cd_rdata} - {{(PERIOD_W + 1 - TICK_W){1'b0}}, r_tick_size};
    assign cd_expired = diff[PERIOD_W] || (diff[PERIOD_W-1:0] == '0);
    assign add_ok     = r_handler && (r_period != '0) && (r_total < CNT_W'(MAX_TASKS))
                        && (r_prio <= PRIO_LIMIT);
    assign scan_end   = (r_idx == r_total);
    assign out_free   = !r_out_valid || o_rsp.ready;

    pts_ram #(.WIDTH(PERIOD_W), .DEPTH(MAX_TASKS)) u_period_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (total_addr),
        .i_wdata (r_period),
        .i_raddr (r_pick),
        .o_rdata (per_rdata)
    );

    pts_ram #(.WIDTH(PERIOD_W), .DEPTH(MAX_TASKS)) u_countdown_ram (
        .i_clk   (i_clk),
        .i_we    (cd_we),
        .i_waddr (cd_waddr),
        .i_wdata (cd_wdata),
        .i_raddr (idx_addr),
        .o_rdata (cd_rdata)
    );

    pts_ram #(.WIDTH(PRIO_W), .DEPTH(MAX_TASKS)) u_priority_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (total_addr),
        .i_wdata (r_prio),
        .i_raddr (idx_addr),
        .o_rdata (prio_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    unique case (i_req.func)
                        FUNC_CLEAR: n_state = ST_RESP;
                        FUNC_ADD:   n_state = ST_ADD;
                        FUNC_TICK:  n_state = ST_TICK_RD;
                        FUNC_RUN:   n_state = ST_RUN_RD;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ADD:       n_state = ST_RESP;
            ST_TICK_RD:   n_state = scan_end ? ST_RESP : ST_TICK_WR;
            ST_TICK_WR:   n_state = ST_TICK_RD;
            ST_RUN_RD: begin
                if (!scan_end) begin
                    n_state = ST_RUN_CMP;
                end else if (r_found) begin
                    n_state = ST_RUN_FETCH;
                end else begin
                    n_state = ST_RESP;
                end
            end
            ST_RUN_CMP:   n_state = ST_RUN_RD;
            ST_RUN_FETCH: n_state = ST_RUN_ARM;
            ST_RUN_ARM:   n_state = ST_RESP;
            ST_RESP:      n_state = out_free ? ST_IDLE : ST_RESP;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = 1'b0;
        tab_we      = 1'b0;
        cd_we       = 1'b0;
        cd_waddr    = idx_addr;
        cd_wdata    = '0;
        unique case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
            end
            ST_ADD: begin
                tab_we   = add_ok;
                cd_we    = add_ok;
                cd_waddr = total_addr;
                cd_wdata = r_period;
            end
            ST_TICK_WR: begin
                cd_we    = 1'b1;
                cd_waddr = idx_addr;
                cd_wdata = cd_expired ? '0 : diff[PERIOD_W-1:0];
            end
            ST_RUN_ARM: begin
                cd_we    = 1'b1;
                cd_waddr = r_pick;
                cd_wdata = per_rdata;
            end
            default: begin
                i_req.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tick_size <= TICK_W'(1);
            r_total     <= '0;
            r_ready     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_tick_size <= i_cfg_wdata;
            end
            if (r_state == ST_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req.valid && i_req.func == FUNC_CLEAR) begin
                        r_total <= '0;
                        r_ready <= '0;
                    end
                end
                ST_ADD: begin
                    if (add_ok) begin
                        r_total             <= r_total + CNT_W'(1);
                        r_ready[total_addr] <= 1'b0;
                    end
                end
                ST_TICK_WR: begin
                    if (cd_expired) begin
                        r_ready[idx_addr] <= 1'b1;
                    end
                end
                ST_RUN_ARM: begin
                    r_ready[r_pick] <= 1'b0;
                end
                default: begin
                    r_total <= r_total;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_handler <= i_req.handler_present;
                r_period  <= i_req.period;
                r_prio    <= i_req.priority_req;
                r_idx     <= '0;
                r_found   <= 1'b0;
                r_best    <= '0;
                r_pick    <= '0;
                r_res     <= '{status: STATUS_DONE, task_index: '0, dispatch: 1'b0};
            end
            ST_ADD: begin
                if (add_ok) begin
                    r_res <= '{status: STATUS_DONE, task_index: TASK_IDX_W'(total_addr),
                               dispatch: 1'b0};
                end else begin
                    r_res <= '{status: STATUS_REJECTED, task_index: '0, dispatch: 1'b0};
                end
            end
            ST_TICK_WR: begin
                r_idx <= r_idx + CNT_W'(1);
            end
            ST_RUN_RD: begin
                if (scan_end && !r_found) begin
                    r_res <= '{status: STATUS_NO_READY, task_index: '0, dispatch: 1'b0};
                end
            end
            ST_RUN_CMP: begin
                if (r_ready[idx_addr] && (!r_found || prio_rdata < r_best)) begin
                    r_found <= 1'b1;
                    r_best  <= prio_rdata;
                    r_pick  <= idx_addr;
                end
                r_idx <= r_idx + CNT_W'(1);
            end
            ST_RUN_ARM: begin
                r_res <= '{status: STATUS_DONE, task_index: TASK_IDX_W'(r_pick),
                           dispatch: 1'b1};
            end
            ST_RESP: begin
                if (out_free) begin
                    r_out <= r_res;
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.task_index = r_out.task_index;
    assign o_rsp.dispatch   = r_out.dispatch;

endmodule

`default_nettype wire
